[design/gbs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and sizes for the streaming 3x3 Gaussian blur
// Pixel, index and configuration widths used by the channels and the core.
// ----------------------------------------------------------------------------
package gbs_pkg;

   localparam int MAX_SIZE = 4096;
   localparam int MIN_SIZE = 3;
   localparam int PIX_W    = 8;
   localparam int IDX_W    = $clog2(MAX_SIZE);
   localparam int CFG_W    = 13;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CFG_W-1:0] cfg_type;

   // One image column: index 0 = two rows above, 1 = row above, 2 = current row
   typedef logic [2:0][PIX_W-1:0] column_type;

endpackage : gbs_pkg
`default_nettype wire

[design/gbs_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_req_if: request channel carrying one source pixel
// Valid/ready handshake; a request moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface gbs_req_if;
   import gbs_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);

endinterface : gbs_req_if
`default_nettype wire

[design/gbs_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_rsp_if: response channel carrying one filtered pixel and its position
// Valid/ready handshake; a response moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface gbs_rsp_if;
   import gbs_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type pixel_out;
   idx_type   out_row;
   idx_type   out_col;
   logic      last_of_run;

   modport source (output valid, output pixel_out, output out_row, output out_col,
                   output last_of_run, input ready);
   modport sink   (input valid, input pixel_out, input out_row, input out_col,
                   input last_of_run, output ready);

endinterface : gbs_rsp_if
`default_nettype wire

[design/gaussian_blur_3x3_stream.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream: streaming 3x3 Gaussian blur of a square 8-bit image
// Feed pixels in raster order on req_ch, one per request. Each result on rsp_ch
// carries the blurred pixel, its row and column, and last_of_run on the final
// result caused by that request. Write the side length on csr_wr_en/csr_wr_data
// only while idle; the write restarts the frame at row 0, column 0.
// A request taken at a rising edge sits in the input register; its first result
// then loads into the output register, from which the receiver takes it.
// Throughput: one request per clock while the receiver is ready and each request
// gives at most one result. Row 0 and column 0 give no result, row ends give two,
// each pixel of the last row two, the final pixel four. The one output register
// sends one result per clock while the receiver is ready; a request with several
// results holds req_ch.ready low until its last result loads.
// Reset: counters, window and handshake state clear; size returns to 4096.
// The line stores are not cleared (no clearing pass): entries never written
// only land in border positions that are replaced before use.
// A stalled receiver holds the output register; one request waits in the
// input register, and req_ch.ready drops until its results drain.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_stream (
   input  logic                      clock,
   input  logic                      reset,
   gbs_req_if.sink                   req_ch,
   gbs_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [gbs_pkg::CFG_W-1:0] csr_wr_data
);
   import gbs_pkg::*;

   localparam int               SUM_W      = PIX_W + 4;
   localparam int               MUL_W      = 13;
   localparam int               DIV9_SHIFT = 16;
   // ceil(2^16 / 9): exact for every corner sum up to 9 * 255
   localparam logic [MUL_W-1:0] DIV9_MUL   = MUL_W'(7282);

   // Result slots of one request, in output order
   typedef enum logic [3:0] {
      SLOT_PREV_ROW = 4'b0001,   // row r-1, column c-1
      SLOT_CUR_ROW  = 4'b0010,   // row r,   column c-1 (last row only)
      SLOT_EDGE_PRV = 4'b0100,   // row r-1, column c   (row end only)
      SLOT_EDGE_CUR = 4'b1000    // row r,   column c   (final pixel only)
   } slot_type;

   typedef logic [2:0][2:0][PIX_W-1:0] window_type;   // [row][col]

   // Configuration and position
   idx_type    size_m1_ff, size_m1_in;
   idx_type    row_ff, col_ff, row_in, col_in;

   // Two previous columns of the window
   column_type win_old_ff, win_new_ff;

   // Input register
   logic       s1_valid_ff;
   pixel_type  s1_pixel_ff;
   idx_type    s1_row_ff, s1_col_ff;
   pixel_type  older_rd_ff, newer_rd_ff;
   slot_type   slot_ff, slot_in;

   // Output register
   logic       out_valid_ff;
   pixel_type  out_pixel_ff;
   idx_type    out_row_ff, out_col_ff;
   logic       out_last_ff;

   // Line stores
   pixel_type  older_mem [MAX_SIZE];
   pixel_type  newer_mem [MAX_SIZE];

   logic       req_accept, out_load, s1_emit, s1_emit_go, s1_retire;
   logic       last_row, last_col, slot_last, slot_off, slot_right;
   column_type cur_col, col_l, col_m, col_r;
   logic [1:0] r0, r1;
   window_type win;
   idx_type    res_row, res_col;
   pixel_type  res_pixel;

   function automatic pixel_type blur_px(input window_type w_in, input logic top,
                                         input logic bot, input logic lft,
                                         input logic rgt);
      window_type               w;
      logic [SUM_W-1:0]         sum;
      logic [SUM_W+MUL_W-1:0]   prod;
      pixel_type                h, v, d;
      pixel_type                res;
      w = w_in;
      if (top) begin
         w[0] = w[1];
      end
      if (bot) begin
         w[2] = w[1];
      end
      if (lft) begin
         w[0][0] = w[0][1];
         w[1][0] = w[1][1];
         w[2][0] = w[2][1];
      end
      if (rgt) begin
         w[0][2] = w[0][1];
         w[1][2] = w[1][1];
         w[2][2] = w[2][1];
      end
      h = lft ? w[1][2] : w[1][0];
      v = top ? w[2][1] : w[0][1];
      d = w[top ? 2'd2 : 2'd0][lft ? 2'd2 : 2'd0];
      if ((top || bot) && (lft || rgt)) begin
         // corner: four real pixels, weights 4,2,2,1, divided by 9
         sum  = (SUM_W'(w[1][1]) << 2) + (SUM_W'(h) << 1) + (SUM_W'(v) << 1)
              + SUM_W'(d);
         prod = (SUM_W+MUL_W)'(sum) * (SUM_W+MUL_W)'(DIV9_MUL);
         res  = prod[DIV9_SHIFT +: PIX_W];
      end else begin
         sum  = SUM_W'(w[0][0]) + (SUM_W'(w[0][1]) << 1) + SUM_W'(w[0][2])
              + (SUM_W'(w[1][0]) << 1) + (SUM_W'(w[1][1]) << 2)
              + (SUM_W'(w[1][2]) << 1)
              + SUM_W'(w[2][0]) + (SUM_W'(w[2][1]) << 1) + SUM_W'(w[2][2]);
         prod = '0;
         res  = sum[SUM_W-1 -: PIX_W];
      end
      return res;
   endfunction

   // Clamp the written size into [MIN_SIZE, MAX_SIZE], keep size - 1
   always_comb begin
      priority if (csr_wr_data < CFG_W'(MIN_SIZE)) begin
         size_m1_in = IDX_W'(MIN_SIZE - 1);
      end else if (csr_wr_data > CFG_W'(MAX_SIZE)) begin
         size_m1_in = IDX_W'(MAX_SIZE - 1);
      end else begin
         size_m1_in = IDX_W'(csr_wr_data - CFG_W'(1));
      end
   end

   // Raster position of the next request
   always_comb begin
      row_in = row_ff;
      col_in = col_ff + IDX_W'(1);
      if (col_ff == size_m1_ff) begin
         col_in = '0;
         row_in = (row_ff == size_m1_ff) ? '0 : row_ff + IDX_W'(1);
      end
   end

   // Handshake: the output register frees whenever the receiver takes it
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign out_load     = !out_valid_ff || rsp_ch.ready;
   assign s1_emit      = (s1_row_ff != '0) && (s1_col_ff != '0);
   assign s1_emit_go   = s1_valid_ff && s1_emit && out_load;
   assign s1_retire    = s1_valid_ff && (!s1_emit || (out_load && slot_last));
   assign req_ch.ready = !s1_valid_ff || s1_retire;

   assign last_row = (s1_row_ff == size_m1_ff);
   assign last_col = (s1_col_ff == size_m1_ff);
   assign cur_col  = {s1_pixel_ff, newer_rd_ff, older_rd_ff};

   // Walk the slots of the current request, skip those that do not apply
   always_comb begin
      unique case (slot_ff)
         SLOT_PREV_ROW: begin
            slot_off   = 1'b0;
            slot_right = 1'b0;
            slot_last  = !last_row && !last_col;
            slot_in    = last_row ? SLOT_CUR_ROW : SLOT_EDGE_PRV;
         end
         SLOT_CUR_ROW: begin
            slot_off   = 1'b1;
            slot_right = 1'b0;
            slot_last  = !last_col;
            slot_in    = SLOT_EDGE_PRV;
         end
         SLOT_EDGE_PRV: begin
            slot_off   = 1'b0;
            slot_right = 1'b1;
            slot_last  = !last_row;
            slot_in    = SLOT_EDGE_CUR;
         end
         SLOT_EDGE_CUR: begin
            slot_off   = 1'b1;
            slot_right = 1'b1;
            slot_last  = 1'b1;
            slot_in    = SLOT_PREV_ROW;
         end
         default: begin
            slot_off   = 1'b0;
            slot_right = 1'b0;
            slot_last  = 1'b1;
            slot_in    = SLOT_PREV_ROW;
         end
      endcase
   end

   // Build the 3x3 window for the selected slot. At the right edge the current
   // column doubles as the right column; the border repetition then replaces it.
   always_comb begin
      col_l = slot_right ? win_new_ff : win_old_ff;
      col_m = slot_right ? cur_col : win_new_ff;
      col_r = cur_col;
      // centre on the current row: shift rows up, bottom repeats
      r0 = slot_off ? 2'd1 : 2'd0;
      r1 = slot_off ? 2'd2 : 2'd1;
      win[0] = {col_r[r0], col_m[r0], col_l[r0]};
      win[1] = {col_r[r1], col_m[r1], col_l[r1]};
      win[2] = {col_r[2],  col_m[2],  col_l[2]};
      res_row = slot_off ? s1_row_ff : s1_row_ff - IDX_W'(1);
      res_col = slot_right ? s1_col_ff : s1_col_ff - IDX_W'(1);
      res_pixel = blur_px(win, res_row == '0, res_row == size_m1_ff,
                          res_col == '0, res_col == size_m1_ff);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         size_m1_ff   <= IDX_W'(MAX_SIZE - 1);
         row_ff       <= '0;
         col_ff       <= '0;
         win_old_ff   <= '0;
         win_new_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         slot_ff      <= SLOT_PREV_ROW;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            // new size: restart the frame, drop the window
            size_m1_ff <= size_m1_in;
            row_ff     <= '0;
            col_ff     <= '0;
            win_old_ff <= '0;
            win_new_ff <= '0;
         end else begin
            if (req_accept) begin
               row_ff <= row_in;
               col_ff <= col_in;
            end
            if (s1_retire) begin
               win_old_ff <= win_new_ff;
               win_new_ff <= cur_col;
            end
         end

         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_retire) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_retire) begin
            slot_ff <= SLOT_PREV_ROW;
         end else if (s1_emit_go) begin
            slot_ff <= slot_in;
         end

         if (s1_emit_go) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload, line stores: read at accept, write back when the request leaves
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_ch.pixel_in;
         s1_row_ff   <= row_ff;
         s1_col_ff   <= col_ff;
         older_rd_ff <= older_mem[col_ff];
         newer_rd_ff <= newer_mem[col_ff];
      end
      if (s1_retire) begin
         older_mem[s1_col_ff] <= newer_rd_ff;
         newer_mem[s1_col_ff] <= s1_pixel_ff;
      end
      if (s1_emit_go) begin
         out_pixel_ff <= res_pixel;
         out_row_ff   <= res_row;
         out_col_ff   <= res_col;
         out_last_ff  <= slot_last;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.pixel_out   = out_pixel_ff;
   assign rsp_ch.out_row     = out_row_ff;
   assign rsp_ch.out_col     = out_col_ff;
   assign rsp_ch.last_of_run = out_last_ff;

endmodule : gaussian_blur_3x3_stream
`default_nettype wire

[design/gbs_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_checker: port-level checks for the streaming 3x3 Gaussian blur
// Watches the response channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module gbs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [gbs_pkg::PIX_W-1:0] pixel_out,
   input logic [gbs_pkg::IDX_W-1:0] out_row,
   input logic [gbs_pkg::IDX_W-1:0] out_col,
   input logic                      last_of_run
);
   import gbs_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(pixel_out) && $stable(out_row)
                                  && $stable(out_col) && $stable(last_of_run))
      else $error("response payload changed while stalled");

   // Reset empties the output register
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A run of results from one request drains without gaps
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_of_run |=> rsp_valid)
      else $error("gap inside a run of results");

   // Within a run the column stays or moves right by one
   a_run_column: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_of_run |=>
         (out_col == $past(out_col)) || (out_col == $past(out_col) + IDX_W'(1)))
      else $error("column out of order inside a run");

endmodule : gbs_checker

bind gaussian_blur_3x3_stream gbs_checker u_gbs_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .pixel_out   (rsp_ch.pixel_out),
   .out_row     (rsp_ch.out_row),
   .out_col     (rsp_ch.out_col),
   .last_of_run (rsp_ch.last_of_run)
);
`default_nettype wire

[dv/blur_check_pkg.sv]
// ----------------------------------------------------------------------------
// blur_check_pkg: expected-pixel tracker for the streaming 3x3 Gaussian blur
// Mirrors the line stores, window and raster counters of the block, works out
// the filtered pixels each source pixel releases, and checks them in order.
// ----------------------------------------------------------------------------
package blur_check_pkg;
   import gbs_pkg::*;

   typedef struct packed {
      pixel_type pix;
      idx_type   row;
      idx_type   col;
      logic      last;
   } blurred_pixel_type;

   class blur_tracker_type;
      pixel_type         older_row [MAX_SIZE];
      pixel_type         newer_row [MAX_SIZE];
      column_type        col_two_back;
      column_type        col_one_back;
      int unsigned       next_row;
      int unsigned       next_col;
      cfg_type           size_reg;
      blurred_pixel_type expected_pixels [$];
      int unsigned       mismatches;

      function new();
         foreach (older_row[i]) begin
            older_row[i] = '0;
            newer_row[i] = '0;
         end
         col_two_back = '0;
         col_one_back = '0;
         next_row     = 0;
         next_col     = 0;
         size_reg     = cfg_type'(MAX_SIZE);
         mismatches   = 0;
      endfunction

      // Side length in use: clamp the register to the supported range.
      function int unsigned side();
         int unsigned v;
         v = size_reg;
         if (v < MIN_SIZE) v = MIN_SIZE;
         if (v > MAX_SIZE) v = MAX_SIZE;
         return v;
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      // A size write restarts the frame; line stores keep their contents.
      function void set_size(cfg_type v);
         size_reg     = v;
         next_row     = 0;
         next_col     = 0;
         col_two_back = '0;
         col_one_back = '0;
      endfunction

      function pixel_type filter_at(column_type cl, column_type cm, column_type cr,
                                    int unsigned off, int unsigned rr,
                                    int unsigned jj, int unsigned s);
         int unsigned w [3][3];
         int unsigned sum, horiz, vert, diag, k, i;
         bit          top, bot, lft, rgt;
         for (i = 0; i < 3; i++) begin
            k = (i + off > 2) ? 2 : i + off;
            w[i][0] = cl[k];
            w[i][1] = cm[k];
            w[i][2] = cr[k];
         end
         top = (rr == 0);
         bot = (rr == s - 1);
         lft = (jj == 0);
         rgt = (jj == s - 1);
         // Repeat border rows first, then border columns.
         for (i = 0; i < 3; i++) begin
            if (top) w[0][i] = w[1][i];
            if (bot) w[2][i] = w[1][i];
         end
         for (i = 0; i < 3; i++) begin
            if (lft) w[i][0] = w[i][1];
            if (rgt) w[i][2] = w[i][1];
         end
         if ((top || bot) && (lft || rgt)) begin
            horiz = lft ? w[1][2] : w[1][0];
            vert  = top ? w[2][1] : w[0][1];
            diag  = w[top ? 2 : 0][lft ? 2 : 0];
            sum   = 4 * w[1][1] + 2 * horiz + 2 * vert + diag;
            return pixel_type'(sum / 9);
         end
         sum = w[0][0] + 2 * w[0][1] + w[0][2]
             + 2 * w[1][0] + 4 * w[1][1] + 2 * w[1][2]
             + w[2][0] + 2 * w[2][1] + w[2][2];
         return pixel_type'(sum / 16);
      endfunction

      function void expect_blur(pixel_type p, int unsigned rr, int unsigned jj);
         blurred_pixel_type e;
         e.pix  = p;
         e.row  = idx_type'(rr);
         e.col  = idx_type'(jj);
         e.last = 1'b0;
         expected_pixels = {expected_pixels, e};
      endfunction

      // Note one accepted source pixel and queue the results it releases.
      function void note_pixel(pixel_type px);
         int unsigned s, r, c;
         column_type  cur;
         s = side();
         r = next_row;
         c = next_col;
         if (c >= s) c = 0;
         if (r >= s) r = 0;
         cur[0] = older_row[c];
         cur[1] = newer_row[c];
         cur[2] = px;
         if (r >= 1 && c >= 1) begin
            expect_blur(filter_at(col_two_back, col_one_back, cur, 0, r - 1, c - 1, s),
                        r - 1, c - 1);
            if (r == s - 1)
               expect_blur(filter_at(col_two_back, col_one_back, cur, 1, r, c - 1, s),
                           r, c - 1);
            if (c == s - 1) begin
               expect_blur(filter_at(col_one_back, cur, cur, 0, r - 1, c, s), r - 1, c);
               if (r == s - 1)
                  expect_blur(filter_at(col_one_back, cur, cur, 1, r, c, s), r, c);
            end
            expected_pixels[expected_pixels.size() - 1].last = 1'b1;
         end
         older_row[c] = cur[1];
         newer_row[c] = cur[2];
         col_two_back = col_one_back;
         col_one_back = cur;
         c++;
         if (c >= s) begin
            c = 0;
            r++;
            if (r >= s) r = 0;
         end
         next_row = r;
         next_col = c;
      endfunction

      task flag_mismatch(string msg);
         mismatches++;
         $display("mismatch: %s", msg);
      endtask

      task check_result(pixel_type p, idx_type rr, idx_type cc, logic last);
         blurred_pixel_type e;
         if (expected_pixels.size() == 0) begin
            flag_mismatch($sformatf("unexpected result row %0d col %0d pixel %0d",
                                    rr, cc, p));
         end else begin
            e = expected_pixels.pop_front();
            if (p !== e.pix)
               flag_mismatch($sformatf("pixel at (%0d,%0d): got %0d, want %0d",
                                       e.row, e.col, p, e.pix));
            if (rr !== e.row)
               flag_mismatch($sformatf("row at (%0d,%0d): got %0d", e.row, e.col, rr));
            if (cc !== e.col)
               flag_mismatch($sformatf("col at (%0d,%0d): got %0d", e.row, e.col, cc));
            if (last !== e.last)
               flag_mismatch($sformatf("last_of_run at (%0d,%0d): got %0b, want %0b",
                                       e.row, e.col, last, e.last));
         end
      endtask
   endclass

endpackage : blur_check_pkg

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stream test of the 3x3 Gaussian blur
// Streams square images through the block under several side lengths, with
// random idling on both channels and one long receiver hold, and checks every
// filtered pixel, its position and its last-of-run flag against a tracker.
// ----------------------------------------------------------------------------
module tb_top;
   import gbs_pkg::*;
   import blur_check_pkg::*;

   localparam int unsigned RANDOM_ITEMS   = 200;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned SQUEEZE_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES   = 8;

   logic    clock;
   logic    reset;
   logic    csr_wr_en;
   cfg_type csr_wr_data;

   gbs_req_if req_ch ();
   gbs_rsp_if rsp_ch ();

   gaussian_blur_3x3_stream uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   blur_tracker_type tracker;
   bit               idle_on;          // cleared for the closing stretch of the run
   bit               squeeze_request;  // asks the receiver for one long hold
   int unsigned      pixels_sent;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver pacing: hold ready low in random bursts, toggle into calm
   // stretches with no idling, and honor one long hold when asked.
   initial begin : rsp_pacing
      int unsigned gap_left, hold_left;
      bit          calm;
      gap_left     = 0;
      hold_left    = 0;
      calm         = 1'b0;
      rsp_ch.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (squeeze_request) begin
            squeeze_request = 1'b0;
            hold_left       = SQUEEZE_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = 1'b1;
            if ($urandom_range(0, 63) == 0) calm = !calm;
            if (idle_on && !calm && $urandom_range(0, 7) == 0)
               gap_left = $urandom_range(1, 19);
         end
         @(negedge clock);
      end
   end

   // Check each response taken at a rising edge against the oldest expectation.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         tracker.check_result(rsp_ch.pixel_out, rsp_ch.out_row, rsp_ch.out_col,
                              rsp_ch.last_of_run);
   end

   // Watchdog: end the run once nothing has moved for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_wr_en)
            quiet = 0;
         else
            quiet++;
      end
      $display("status: fail");
      $finish;
   end

   // Bias toward the extremes of the pixel range.
   function automatic pixel_type pick_pixel();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return pixel_type'($urandom_range(0, 255));
   endfunction

   // Offer one request at the falling edge and hold it until taken. Valid
   // stays high on return so back-to-back requests never drop it.
   task automatic send_pixel(pixel_type px);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.pixel_in = px;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      tracker.note_pixel(px);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic send_pixels(int unsigned count);
      repeat (count) send_pixel(pick_pixel());
   endtask

   // Drop valid, drain every pending result, then wait DRAIN_CYCLES so that
   // a request that released nothing can leave the block.
   task automatic settle();
      req_ch.valid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_size(cfg_type value);
      settle();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      tracker.set_size(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // One random setting: mostly small images in whole frames, sometimes a
   // frame abandoned partway, sometimes a large size that only starts a frame.
   task automatic random_phase();
      int unsigned pick, s;
      pick = $urandom_range(0, 15);
      if (pick == 1) begin
         write_size(cfg_type'($urandom_range(10, 8191)));
         send_pixels($urandom_range(1, 40));
      end else begin
         if (pick == 0)
            write_size(cfg_type'($urandom_range(0, 2)));
         else
            write_size(cfg_type'($urandom_range(3, 8)));
         s = tracker.side();
         send_pixels($urandom_range(1, 2) * s * s);
         if ($urandom_range(0, 3) == 0) send_pixels($urandom_range(1, s * s - 1));
      end
   endtask

   initial begin : stimulus
      int unsigned i, base;
      tracker         = new();
      idle_on         = 1'b1;
      squeeze_request = 1'b0;
      pixels_sent     = 0;
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_ch.valid    = 1'b0;
      req_ch.pixel_in = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Default size after reset: a few pixels of row 0, which release nothing.
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h5A);

      // Size below the minimum clamps to 3; an all-white frame drives the
      // largest sums through every corner, edge and interior result.
      write_size(cfg_type'(0));
      repeat (9) send_pixel(8'hFF);

      // Checkerboard of black and white at size 2 (also clamped to 3).
      write_size(cfg_type'(2));
      for (i = 0; i < 9; i++)
         send_pixel(((i / 3 + i % 3) % 2 != 0) ? 8'hFF : 8'h00);

      // Start a frame and leave it: the next size write restarts mid-frame.
      write_size(cfg_type'(3));
      send_pixel(8'h01);
      send_pixel(8'h80);
      send_pixel(8'hFE);
      send_pixel(8'h7F);

      // Long receiver hold while requests keep coming: fill the block and
      // stall its input.
      write_size(cfg_type'(6));
      squeeze_request = 1'b1;
      send_pixels(72);

      base = pixels_sent;
      while (pixels_sent - base < RANDOM_ITEMS) random_phase();

      // All-ones size clamps to the maximum; a short start of row 0 releases
      // nothing.
      write_size(cfg_type'(13'h1FFF));
      send_pixels(16);

      // Closing stretch with no idling on either side.
      idle_on = 1'b0;
      write_size(cfg_type'(4));
      send_pixels(32);
      settle();

      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule : tb_top

[files.f]
design/gbs_pkg.sv
design/gbs_req_if.sv
design/gbs_rsp_if.sv
design/gaussian_blur_3x3_stream.sv
design/gbs_checker.sv
dv/blur_check_pkg.sv
dv/tb_top.sv
